// ----- rtl/tqs_pkg.sv -----
// shared types and constants of the timer queue scheduler
package tqs_pkg;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  slot;
        logic [31:0] timeout_ms;
        logic [15:0] elapsed_ms;
        logic [31:0] seconds;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_index;
        logic [15:0] fire_count;
        logic [63:0] time_ms;
        logic        last;
    } rsp_t;

    localparam logic [2:0] MODE_TICK     = 3'd0;
    localparam logic [2:0] MODE_ONESHOT  = 3'd1;
    localparam logic [2:0] MODE_PERIODIC = 3'd2;
    localparam logic [2:0] MODE_RESTART  = 3'd3;
    localparam logic [2:0] MODE_STOP     = 3'd4;
    localparam logic [2:0] MODE_CANCEL   = 3'd5;
    localparam logic [2:0] MODE_SET      = 3'd6;
    localparam logic [2:0] MODE_ADVANCE  = 3'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FIRE     = 3'd1;
    localparam logic [2:0] ST_NO_SLOT  = 3'd2;
    localparam logic [2:0] ST_BAD_SLOT = 3'd3;
    localparam logic [2:0] ST_ZERO_PER = 3'd4;

    localparam logic [4:0]  MAX_FIRES = 5'd16;
    localparam logic [63:0] MS_PER_S  = 64'd1000;
    localparam logic [15:0] CAP_RESET = 16'd10;

endpackage

// ----- rtl/tqs_div.sv -----
// restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle
module tqs_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [31:0] remainder
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [32:0] trial;

    assign trial = {rem_reg, quo_reg[63]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'd0;
            quo_next  = dividend;
            rem_next  = 32'd0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = 32'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/timer_queue_scheduler_top.sv -----
// timer queue scheduler top level: slot memories, command sequencer, tick scan
//
// requests enter on req_valid/req_ready, one command each; results leave on
// rsp_valid/rsp_ready, one or more per request, the final one marked by last.
// the user must write catchup_cap through cfg_we/cfg_data only while the block
// is idle; the block itself does not enforce it. a request is taken only in the
// idle state; one request is worked at a time. set time, advance, stop, cancel,
// restart and zero-period schedules go from idle straight to the emit state; a
// schedule walks the slot flags for a free one. a tick scans the slot memory
// once per fire, and a periodic fire waits on the serial divider that forms the
// catch-up count; a tick gives up to 16 fires.
// an output register holds each result; the next request is taken while it
// waits, but a further result waits until rsp_ready takes the held one.
// reset clears the clock, the slot flags and the insertion counter and sets
// catchup_cap to 10; the slot memories need no clearing.
module timer_queue_scheduler_top #(
    parameter int SLOTS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  tqs_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output tqs_pkg::rsp_t rsp,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
    localparam logic [8:0] SLOTS_W = 9'(SLOTS);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_FREE = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_PROC = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_NEXT = 7'b0100000,
        S_EMIT = 7'b1000000
    } state_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_index;
        logic [15:0] fire_count;
        logic        last;
    } emit_t;

    state_t state_reg, state_next, after_reg, after_next;
    logic [63:0] now_reg, now_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [15:0] cap_reg, cap_next;
    logic [SLOTS-1:0] alloc_reg, alloc_next, armed_reg, armed_next;
    logic [SLOTS-1:0] rep_reg, rep_next, done_reg, done_next;
    tqs_pkg::req_t req_reg, req_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic rd_live_reg, rd_live_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic best_found_reg, best_found_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic [63:0] best_due_reg, best_due_next;
    logic [31:0] best_age_reg, best_age_next;
    logic [31:0] best_per_reg, best_per_next;
    logic pend_valid_reg, pend_valid_next;
    logic [IW-1:0] pend_slot_reg, pend_slot_next;
    logic [15:0] pend_count_reg, pend_count_next;
    logic [4:0] fires_reg, fires_next;
    emit_t emit_reg, emit_next;
    tqs_pkg::rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg, rsp_valid_next;

    logic [95:0] ds_mem [SLOTS];
    logic [31:0] per_mem [SLOTS];
    logic [95:0] ds_q_reg;
    logic [31:0] per_q_reg;
    logic        dw_en, pw_en;
    logic [IW-1:0] dw_addr, pw_addr, rd_addr;
    logic [95:0] dw_data;
    logic [31:0] pw_data;

    logic        div_start, div_done;
    logic [63:0] div_q;
    logic [31:0] div_r;

    logic [63:0] cand_due;
    logic [31:0] cand_age;
    logic [IW-1:0] tgt_idx;
    logic        tgt_bad;
    logic [15:0] cap1;
    logic [15:0] fire_cnt;

    assign rd_addr  = cnt_reg[IW-1:0];
    assign cand_due = ds_q_reg[95:32];
    assign cand_age = stamp_reg - ds_q_reg[31:0];
    assign tgt_idx  = IW'(req.slot);
    assign tgt_bad  = ({5'd0, req.slot} >= SLOTS_W) || !alloc_reg[tgt_idx];
    assign cap1     = (cap_reg == 16'd0) ? 16'd1 : cap_reg;
    assign fire_cnt = (div_q >= {48'd0, cap1}) ? cap1 : div_q[15:0] + 16'd1;

    tqs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (now_reg - best_due_reg),
        .divisor   (best_per_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        state_next      = state_reg;
        after_next      = after_reg;
        now_next        = now_reg;
        stamp_next      = stamp_reg;
        cap_next        = cfg_we ? cfg_data : cap_reg;
        alloc_next      = alloc_reg;
        armed_next      = armed_reg;
        rep_next        = rep_reg;
        done_next       = done_reg;
        req_next        = req_reg;
        cnt_next        = cnt_reg;
        rd_live_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_due_next   = best_due_reg;
        best_age_next   = best_age_reg;
        best_per_next   = best_per_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_count_next = pend_count_reg;
        fires_next      = fires_reg;
        emit_next       = emit_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        dw_en           = 1'b0;
        dw_addr         = best_idx_reg;
        dw_data         = {now_reg + 64'(req.timeout_ms), stamp_reg};
        pw_en           = 1'b0;
        pw_addr         = rd_addr;
        pw_data         = 32'd0;
        div_start       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    emit_next  = '{status: tqs_pkg::ST_OK, slot_index: 4'd0,
                                   fire_count: 16'd0, last: 1'b1};
                    after_next = S_IDLE;
                    state_next = S_EMIT;
                    case (req.mode)
                        tqs_pkg::MODE_TICK:
                        begin
                            now_next        = now_reg + 64'(req.elapsed_ms);
                            fires_next      = 5'd0;
                            done_next       = '0;
                            pend_valid_next = 1'b0;
                            cnt_next        = '0;
                            best_found_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        tqs_pkg::MODE_ONESHOT, tqs_pkg::MODE_PERIODIC:
                        begin
                            if (req.mode == tqs_pkg::MODE_PERIODIC && req.timeout_ms == 32'd0)
                            begin
                                emit_next.status = tqs_pkg::ST_ZERO_PER;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                state_next = S_FREE;
                            end
                        end
                        tqs_pkg::MODE_RESTART, tqs_pkg::MODE_STOP, tqs_pkg::MODE_CANCEL:
                        begin
                            emit_next.slot_index = req.slot;
                            if (tgt_bad)
                            begin
                                emit_next.status = tqs_pkg::ST_BAD_SLOT;
                            end
                            else if (req.mode == tqs_pkg::MODE_RESTART)
                            begin
                                dw_en               = 1'b1;
                                dw_addr             = tgt_idx;
                                stamp_next          = stamp_reg + 32'd1;
                                armed_next[tgt_idx] = 1'b1;
                            end
                            else
                            begin
                                armed_next[tgt_idx] = 1'b0;
                                if (req.mode == tqs_pkg::MODE_CANCEL)
                                begin
                                    alloc_next[tgt_idx] = 1'b0;
                                    rep_next[tgt_idx]   = 1'b0;
                                end
                            end
                        end
                        tqs_pkg::MODE_SET:
                        begin
                            now_next = {32'd0, req.seconds} * tqs_pkg::MS_PER_S;
                        end
                        default:
                        begin
                            now_next = now_reg + {32'd0, req.seconds} * tqs_pkg::MS_PER_S;
                        end
                    endcase
                end
            end

            S_FREE:
            begin
                if (cnt_reg == SLOTS_C)
                begin
                    emit_next  = '{status: tqs_pkg::ST_NO_SLOT, slot_index: 4'd0,
                                   fire_count: 16'd0, last: 1'b1};
                    after_next = S_IDLE;
                    state_next = S_EMIT;
                end
                else if (!alloc_reg[rd_addr])
                begin
                    alloc_next[rd_addr] = 1'b1;
                    armed_next[rd_addr] = 1'b1;
                    rep_next[rd_addr]   = (req_reg.mode == tqs_pkg::MODE_PERIODIC);
                    pw_en   = 1'b1;
                    pw_data = (req_reg.mode == tqs_pkg::MODE_PERIODIC) ?
                              req_reg.timeout_ms : 32'd0;
                    dw_en   = 1'b1;
                    dw_addr = rd_addr;
                    dw_data = {now_reg + 64'(req_reg.timeout_ms), stamp_reg};
                    stamp_next = stamp_reg + 32'd1;
                    emit_next  = '{status: tqs_pkg::ST_OK, slot_index: 4'(rd_addr),
                                   fire_count: 16'd0, last: 1'b1};
                    after_next = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_SCAN:
            begin
                if (rd_live_reg && armed_reg[rd_idx_reg] && !done_reg[rd_idx_reg]
                    && cand_due <= now_reg)
                begin
                    if (!best_found_reg || cand_due < best_due_reg
                        || (cand_due == best_due_reg && cand_age > best_age_reg))
                    begin
                        best_found_next = 1'b1;
                        best_idx_next   = rd_idx_reg;
                        best_due_next   = cand_due;
                        best_age_next   = cand_age;
                        best_per_next   = per_q_reg;
                    end
                end
                if (cnt_reg != SLOTS_C)
                begin
                    cnt_next     = cnt_reg + 1'b1;
                    rd_live_next = 1'b1;
                    rd_idx_next  = rd_addr;
                end
                else if (!rd_live_reg)
                begin
                    if (best_found_reg)
                    begin
                        if (pend_valid_reg)
                        begin
                            emit_next  = '{status: tqs_pkg::ST_FIRE,
                                           slot_index: 4'(pend_slot_reg),
                                           fire_count: pend_count_reg, last: 1'b0};
                            pend_valid_next = 1'b0;
                            after_next = S_PROC;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_PROC;
                        end
                    end
                    else
                    begin
                        if (pend_valid_reg)
                        begin
                            emit_next  = '{status: tqs_pkg::ST_FIRE,
                                           slot_index: 4'(pend_slot_reg),
                                           fire_count: pend_count_reg, last: 1'b1};
                        end
                        else
                        begin
                            emit_next  = '{status: tqs_pkg::ST_OK, slot_index: 4'd0,
                                           fire_count: 16'd0, last: 1'b1};
                        end
                        pend_valid_next = 1'b0;
                        after_next = S_IDLE;
                        state_next = S_EMIT;
                    end
                end
            end

            S_PROC:
            begin
                done_next[best_idx_reg] = 1'b1;
                fires_next = fires_reg + 5'd1;
                if (rep_reg[best_idx_reg] && best_per_reg != 32'd0)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    armed_next[best_idx_reg] = 1'b0;
                    pend_valid_next = 1'b1;
                    pend_slot_next  = best_idx_reg;
                    pend_count_next = 16'd1;
                    state_next      = S_NEXT;
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    // new due = due + (q + 1) * period = now - rem + period
                    dw_en   = 1'b1;
                    dw_addr = best_idx_reg;
                    dw_data = {now_reg - {32'd0, div_r} + {32'd0, best_per_reg}, stamp_reg};
                    stamp_next      = stamp_reg + 32'd1;
                    pend_valid_next = 1'b1;
                    pend_slot_next  = best_idx_reg;
                    pend_count_next = fire_cnt;
                    state_next      = S_NEXT;
                end
            end

            S_NEXT:
            begin
                if (fires_reg == tqs_pkg::MAX_FIRES)
                begin
                    emit_next  = '{status: tqs_pkg::ST_FIRE, slot_index: 4'(pend_slot_reg),
                                   fire_count: pend_count_reg, last: 1'b1};
                    pend_valid_next = 1'b0;
                    after_next = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    cnt_next        = '0;
                    best_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end

            S_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next = '{status: emit_reg.status, slot_index: emit_reg.slot_index,
                                 fire_count: emit_reg.fire_count, time_ms: now_reg,
                                 last: emit_reg.last};
                    rsp_valid_next = 1'b1;
                    state_next     = after_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            after_reg      <= S_IDLE;
            now_reg        <= 64'd0;
            stamp_reg      <= 32'd0;
            cap_reg        <= tqs_pkg::CAP_RESET;
            alloc_reg      <= '0;
            armed_reg      <= '0;
            rep_reg        <= '0;
            done_reg       <= '0;
            cnt_reg        <= '0;
            rd_live_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            fires_reg      <= 5'd0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            after_reg      <= after_next;
            now_reg        <= now_next;
            stamp_reg      <= stamp_next;
            cap_reg        <= cap_next;
            alloc_reg      <= alloc_next;
            armed_reg      <= armed_next;
            rep_reg        <= rep_next;
            done_reg       <= done_next;
            cnt_reg        <= cnt_next;
            rd_live_reg    <= rd_live_next;
            best_found_reg <= best_found_next;
            pend_valid_reg <= pend_valid_next;
            fires_reg      <= fires_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        rd_idx_reg     <= rd_idx_next;
        best_idx_reg   <= best_idx_next;
        best_due_reg   <= best_due_next;
        best_age_reg   <= best_age_next;
        best_per_reg   <= best_per_next;
        pend_slot_reg  <= pend_slot_next;
        pend_count_reg <= pend_count_next;
        emit_reg       <= emit_next;
        rsp_reg        <= rsp_next;
    end

    // slot memories: due time with insertion stamp, and period
    always_ff @(posedge clk)
    begin
        if (dw_en)
        begin
            ds_mem[dw_addr] <= dw_data;
        end
        if (pw_en)
        begin
            per_mem[pw_addr] <= pw_data;
        end
        ds_q_reg  <= ds_mem[rd_addr];
        per_q_reg <= per_mem[rd_addr];
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- rtl/tqs_checker.sv -----
// port-level checker of the timer queue scheduler and its bind
module tqs_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input tqs_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    a_fire_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == tqs_pkg::ST_FIRE |-> rsp.fire_count != 16'd0)
        else $error("fire without count");

    a_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != tqs_pkg::ST_FIRE |-> rsp.fire_count == 16'd0)
        else $error("count on a non-fire result");

    a_refused_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == tqs_pkg::ST_NO_SLOT || rsp.status == tqs_pkg::ST_ZERO_PER)
        |-> rsp.slot_index == 4'd0 && rsp.last)
        else $error("refused schedule carries a slot");

endmodule

bind timer_queue_scheduler_top tqs_checker u_tqs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ----- tb/testbench.sv -----
// self-checking testbench for the timer queue scheduler
module testbench;

    localparam int NSLOT = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    tqs_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    tqs_pkg::rsp_t rsp;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;

    timer_queue_scheduler_top dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // scheduler mirror
    logic [15:0] cap_reg;
    logic [63:0] clock_ms;
    logic        slot_used [NSLOT];
    logic        slot_armed [NSLOT];
    logic        slot_repeat [NSLOT];
    logic [63:0] slot_due [NSLOT];
    logic [31:0] slot_period [NSLOT];
    logic [31:0] slot_stamp [NSLOT];
    logic [31:0] stamp_next;

    tqs_pkg::rsp_t expected_rsp [$];
    int   errors = 0;
    int   fires_seen = 0;
    int   sent = 0;
    logic idle_on = 1'b1;
    logic hold_rsp = 1'b0;

    function automatic tqs_pkg::rsp_t make_rsp(logic [2:0] st, logic [3:0] s, logic [15:0] c);
        tqs_pkg::rsp_t r;
        r.status = st;
        r.slot_index = s;
        r.fire_count = c;
        r.time_ms = clock_ms;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic arm_timer(int s, logic [63:0] d);
        slot_due[s] = clock_ms + d;
        slot_stamp[s] = stamp_next;
        stamp_next++;
        slot_armed[s] = 1'b1;
    endtask

    task automatic predict_request(tqs_pkg::req_t q);
        logic          fired [NSLOT];
        int            n;
        int            best;
        logic [31:0]   best_age;
        logic [31:0]   age;
        logic [63:0]   quo;
        logic [15:0]   cnt;
        logic [16:0]   lim;
        tqs_pkg::rsp_t r;
        logic          found;
        n = 0;
        found = 1'b0;
        case (q.mode)
            tqs_pkg::MODE_TICK:
            begin
                lim = (cap_reg == 0) ? 17'd1 : {1'b0, cap_reg};
                foreach (fired[i]) fired[i] = 1'b0;
                clock_ms = clock_ms + 64'(q.elapsed_ms);
                while (n < tqs_pkg::MAX_FIRES)
                begin
                    best = -1;
                    best_age = 0;
                    for (int i = 0; i < NSLOT; i++)
                    begin
                        if (!slot_armed[i] || fired[i] || slot_due[i] > clock_ms)
                            continue;
                        age = stamp_next - slot_stamp[i];
                        if (best < 0 || slot_due[i] < slot_due[best] ||
                            (slot_due[i] == slot_due[best] && age > best_age))
                        begin
                            best = i;
                            best_age = age;
                        end
                    end
                    if (best < 0)
                        break;
                    fired[best] = 1'b1;
                    cnt = 16'd1;
                    if (slot_repeat[best] && slot_period[best] != 0)
                    begin
                        quo = (clock_ms - slot_due[best]) / 64'(slot_period[best]);
                        cnt = (quo >= 64'(lim)) ? lim[15:0] : 16'(quo + 1);
                        slot_due[best] += (quo + 1) * 64'(slot_period[best]);
                        slot_stamp[best] = stamp_next;
                        stamp_next++;
                    end
                    else
                        slot_armed[best] = 1'b0;
                    r = make_rsp(tqs_pkg::ST_FIRE, 4'(best), cnt);
                    r.last = 1'b0;
                    expected_rsp.push_back(r);
                    n++;
                end
                if (n == 0)
                    expected_rsp.push_back(make_rsp(tqs_pkg::ST_OK, 4'd0, 16'd0));
                else
                    expected_rsp[$].last = 1'b1;
            end
            tqs_pkg::MODE_ONESHOT, tqs_pkg::MODE_PERIODIC:
            begin
                if (q.mode == tqs_pkg::MODE_PERIODIC && q.timeout_ms == 0)
                    expected_rsp.push_back(make_rsp(tqs_pkg::ST_ZERO_PER, 4'd0, 16'd0));
                else
                begin
                    for (int i = 0; i < NSLOT && !found; i++)
                    begin
                        if (!slot_used[i])
                        begin
                            found = 1'b1;
                            slot_used[i] = 1'b1;
                            slot_repeat[i] = (q.mode == tqs_pkg::MODE_PERIODIC);
                            slot_period[i] = (q.mode == tqs_pkg::MODE_PERIODIC) ?
                                             q.timeout_ms : 32'd0;
                            arm_timer(i, 64'(q.timeout_ms));
                            expected_rsp.push_back(make_rsp(tqs_pkg::ST_OK, 4'(i), 16'd0));
                        end
                    end
                    if (!found)
                        expected_rsp.push_back(make_rsp(tqs_pkg::ST_NO_SLOT, 4'd0, 16'd0));
                end
            end
            tqs_pkg::MODE_RESTART, tqs_pkg::MODE_STOP, tqs_pkg::MODE_CANCEL:
            begin
                if (!slot_used[q.slot])
                    expected_rsp.push_back(make_rsp(tqs_pkg::ST_BAD_SLOT, q.slot, 16'd0));
                else
                begin
                    if (q.mode == tqs_pkg::MODE_RESTART)
                        arm_timer(q.slot, 64'(q.timeout_ms));
                    else
                    begin
                        slot_armed[q.slot] = 1'b0;
                        if (q.mode == tqs_pkg::MODE_CANCEL)
                        begin
                            slot_used[q.slot] = 1'b0;
                            slot_repeat[q.slot] = 1'b0;
                        end
                    end
                    expected_rsp.push_back(make_rsp(tqs_pkg::ST_OK, q.slot, 16'd0));
                end
            end
            tqs_pkg::MODE_SET:
            begin
                clock_ms = 64'(q.seconds) * tqs_pkg::MS_PER_S;
                expected_rsp.push_back(make_rsp(tqs_pkg::ST_OK, 4'd0, 16'd0));
            end
            default:
            begin
                clock_ms = clock_ms + 64'(q.seconds) * tqs_pkg::MS_PER_S;
                expected_rsp.push_back(make_rsp(tqs_pkg::ST_OK, 4'd0, 16'd0));
            end
        endcase
    endtask

    task automatic send_request(tqs_pkg::req_t q);
        while (idle_on && $urandom_range(99) < 23)
            @(negedge clk);
        req <= q;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_request(q);
        sent++;
        @(negedge clk);
        req_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic tqs_pkg::req_t build(logic [2:0] m, logic [3:0] s, logic [31:0] d,
                                            logic [15:0] e, logic [31:0] sec);
        tqs_pkg::req_t q;
        q.mode = m;
        q.slot = s;
        q.timeout_ms = d;
        q.elapsed_ms = e;
        q.seconds = sec;
        return q;
    endfunction

    task automatic drain_results();
        while (expected_rsp.size() != 0)
            @(negedge clk);
        repeat (1500) @(negedge clk);
    endtask

    task automatic write_cap(logic [15:0] v);
        drain_results();
        cfg_data <= v;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        cap_reg = v;
    endtask

    // result checker
    always @(posedge clk)
    begin
        tqs_pkg::rsp_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("unexpected result status %0d", rsp.status);
                errors++;
            end
            else
            begin
                e = expected_rsp.pop_front();
                if (rsp.status == tqs_pkg::ST_FIRE)
                    fires_seen++;
                if (rsp.status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, rsp.status);
                    errors++;
                end
                if (rsp.slot_index !== e.slot_index)
                begin
                    $error("slot_index exp %0d got %0d", e.slot_index, rsp.slot_index);
                    errors++;
                end
                if (rsp.fire_count !== e.fire_count)
                begin
                    $error("fire_count exp %0d got %0d", e.fire_count, rsp.fire_count);
                    errors++;
                end
                if (rsp.time_ms !== e.time_ms)
                begin
                    $error("time_ms exp %0d got %0d", e.time_ms, rsp.time_ms);
                    errors++;
                end
                if (rsp.last !== e.last)
                begin
                    $error("last exp %0d got %0d", e.last, rsp.last);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (hold_rsp)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= !(idle_on && $urandom_range(99) < 23);
    end

    task automatic test_directed();
        send_request(build(tqs_pkg::MODE_TICK, 4'd0, 32'd0, 16'd0, 32'd0));
        send_request(build(tqs_pkg::MODE_PERIODIC, 4'd0, 32'd0, 16'd0, 32'd0));
        send_request(build(tqs_pkg::MODE_STOP, 4'd15, 32'd0, 16'd0, 32'd0));
        send_request(build(tqs_pkg::MODE_RESTART, 4'd3, 32'd0, 16'd0, 32'd0));
        send_request(build(tqs_pkg::MODE_CANCEL, 4'd9, 32'd0, 16'd0, 32'd0));
        send_request(build(tqs_pkg::MODE_ONESHOT, 4'd0, 32'd5, 16'd0, 32'd0));
        send_request(build(tqs_pkg::MODE_ONESHOT, 4'd0, 32'd5, 16'd0, 32'd0));
        send_request(build(tqs_pkg::MODE_PERIODIC, 4'd0, 32'd3, 16'd0, 32'd0));
        send_request(build(tqs_pkg::MODE_PERIODIC, 4'd0, 32'hFFFF_FFFF, 16'd0, 32'd0));
        send_request(build(tqs_pkg::MODE_TICK, 4'd0, 32'd0, 16'hFFFF, 32'd0));
        send_request(build(tqs_pkg::MODE_STOP, 4'd2, 32'd0, 16'd0, 32'd0));
        send_request(build(tqs_pkg::MODE_RESTART, 4'd0, 32'd0, 16'd0, 32'd0));
        send_request(build(tqs_pkg::MODE_CANCEL, 4'd1, 32'd0, 16'd0, 32'd0));
        send_request(build(tqs_pkg::MODE_SET, 4'd0, 32'd0, 16'd0, 32'hFFFF_FFFF));
        send_request(build(tqs_pkg::MODE_ADVANCE, 4'd0, 32'd0, 16'd0, 32'hFFFF_FFFF));
        send_request(build(tqs_pkg::MODE_TICK, 4'd0, 32'd0, 16'd1, 32'd0));
        send_request(build(tqs_pkg::MODE_SET, 4'd0, 32'd0, 16'd0, 32'd0));
        for (int i = 0; i < 17; i++)
            send_request(build(tqs_pkg::MODE_ONESHOT, 4'd0, 32'd0, 16'd0, 32'd0));
        send_request(build(tqs_pkg::MODE_TICK, 4'd0, 32'd0, 16'd0, 32'd0));
        send_request(build(tqs_pkg::MODE_ADVANCE, 4'd0, 32'd0, 16'd0, 32'h0000_0000));
    endtask

    task automatic test_clear_table();
        for (int i = 0; i < NSLOT; i++)
            send_request(build(tqs_pkg::MODE_CANCEL, 4'(i), 32'd0, 16'd0, 32'd0));
    endtask

    task automatic test_random(int count);
        tqs_pkg::req_t q;
        int            k;
        for (int i = 0; i < count; i++)
        begin
            q = tqs_pkg::req_t'({$urandom, $urandom, $urandom});
            k = $urandom_range(99);
            if (k < 30)
            begin
                q.mode = tqs_pkg::MODE_TICK;
                q.elapsed_ms = ($urandom_range(9) == 0) ? 16'($urandom) :
                               16'($urandom_range(40));
            end
            else if (k < 55)
            begin
                q.mode = ($urandom_range(1) == 0) ? tqs_pkg::MODE_ONESHOT :
                         tqs_pkg::MODE_PERIODIC;
                if ($urandom_range(9) != 0)
                    q.timeout_ms = $urandom_range(30);
            end
            else if (k < 80)
            begin
                q.mode = 3'($urandom_range(tqs_pkg::MODE_RESTART, tqs_pkg::MODE_CANCEL));
                if ($urandom_range(9) != 0)
                    q.timeout_ms = $urandom_range(30);
            end
            else if (k < 88)
            begin
                q.mode = tqs_pkg::MODE_ADVANCE;
                if ($urandom_range(3) != 0)
                    q.seconds = $urandom_range(2);
            end
            else if (k < 92)
            begin
                q.mode = tqs_pkg::MODE_SET;
                if ($urandom_range(3) != 0)
                    q.seconds = $urandom_range(5);
            end
            send_request(q);
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_rsp = 1'b1;
                repeat (400) @(negedge clk);
                hold_rsp = 1'b0;
            end
            test_random(12);
        join
        drain_results();
    endtask

    initial
    begin
        clock_ms = '0;
        stamp_next = '0;
        cap_reg = tqs_pkg::CAP_RESET;
        for (int i = 0; i < NSLOT; i++)
        begin
            slot_used[i] = 1'b0;
            slot_armed[i] = 1'b0;
            slot_repeat[i] = 1'b0;
            slot_due[i] = '0;
            slot_period[i] = '0;
            slot_stamp[i] = '0;
        end
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        write_cap(16'd0);
        test_clear_table();
        test_random(40);
        write_cap(16'd1);
        idle_on = 1'b0;
        test_random(25);
        idle_on = 1'b1;
        write_cap(16'hFFFF);
        test_backpressure();
        write_cap(16'd3);
        test_random(45);
        drain_results();
        $display("covered %0d requests, %0d timer fires, caps 0/1/3/10/65535",
                 sent, fires_seen);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
